[rtl/core/pcxrle_pkg.sv]
// Shared types, constants and the byte placement function of the PCX run-length decoder.
package pcxrle_pkg;

    localparam int unsigned MAX_DIMENSION = 32768;
    localparam int unsigned MAX_PLANES    = 4;

    localparam logic [7:0] RUN_MARK_MASK = 8'hC0;
    localparam logic [7:0] RUN_CNT_MASK  = 8'h3F;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_BYTES   = 2'd2;
    localparam logic [1:0] CFG_PLANE_COUNT  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic step;
        logic flush;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_run;
        logic emit;
        logic line_end;
        logic count_last;
        logic hold_valid;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic        emit;
        logic        line_end;
        logic        done_set;
        logic [15:0] col;
        logic [1:0]  plane;
        logic [15:0] row;
    } t_place;

    // Advances the decode position by one decoded byte.
    function automatic t_place place_byte(
        input logic [15:0] col,
        input logic [1:0]  plane,
        input logic [15:0] row,
        input logic [15:0] eff_w,
        input logic [15:0] eff_l,
        input logic [2:0]  eff_p,
        input logic [15:0] eff_h
    );
        logic [16:0] col1;
        logic [2:0]  pl1;
        logic [15:0] row1;
        t_place      p;
        col1       = {1'b0, col} + 17'd1;
        pl1        = {1'b0, plane} + 3'd1;
        row1       = row + 16'd1;
        p.emit     = (col < eff_w);
        p.col      = col1[15:0];
        p.plane    = plane;
        p.row      = row;
        p.line_end = 1'b0;
        p.done_set = 1'b0;
        if (col1 >= {1'b0, eff_l}) begin
            p.col   = 16'd0;
            p.plane = pl1[1:0];
            if (pl1 >= eff_p) begin
                p.plane    = 2'd0;
                p.row      = row1;
                p.done_set = (row1 >= eff_h);
                p.line_end = 1'b1;
            end
        end
        return p;
    endfunction

endpackage

[rtl/core/pcxrle_in_if.sv]
// Input channel carrying encoded image body bytes.
interface pcxrle_in_if;
    logic       valid;
    logic       ready;
    logic       start_image;
    logic [7:0] data_byte;

    modport source (output valid, output start_image, output data_byte, input ready);
    modport sink   (input valid, input start_image, input data_byte, output ready);
endinterface

[rtl/core/pcxrle_out_if.sv]
// Output channel carrying decoded pixel bytes with their position.
interface pcxrle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_value;
    logic [14:0] pixel_row;
    logic [14:0] pixel_column;
    logic [1:0]  pixel_plane;
    logic        last;

    modport source (output valid, output pixel_value, output pixel_row, output pixel_column,
                    output pixel_plane, output last, input ready);
    modport sink   (input valid, input pixel_value, input pixel_row, input pixel_column,
                    input pixel_plane, input last, output ready);
endinterface

[rtl/core/pcx_rle_scanline_decoder.sv]
// Top level of the PCX run-length scanline decoder.
//
//   Channel   Dir  Handshake          Beat contents
//   i_byte    in   valid / ready      start_image, data_byte (encoded body byte)
//   o_pix     out  valid / ready      pixel_value, pixel_row, pixel_column, pixel_plane, last
//   cfg       in   i_cfg_we           i_cfg_idx selects width, height, line bytes, planes
//
// A literal byte or a run header is handled as soon as it is accepted, so such beats stream at one per cycle
// while the output register keeps draining. A run value byte then holds input ready low while
// the run places its decoded bytes (at most 63, fewer when the scanline ends first) and then
// flushes the final result; the single placement unit in the datapath places them one by one.
// Reset is synchronous and active low: the configuration registers go to one and the decode
// position to the top left. A stalled output holds input ready low, and in a run it stops
// every step that must move the held byte out, including a flush that carries a kept byte.
//
// Decoded bytes of a run pass through a one-entry hold register, so the last flag can be
// set on the final kept byte even when padding columns follow it within the run.
module pcx_rle_scanline_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    pcxrle_in_if.sink            i_byte,
    pcxrle_out_if.source         o_pix
);

    pcxrle_pkg::t_dp_cmd  cmd;
    pcxrle_pkg::t_dp_stat stat;
    logic                 in_ready;

    // The controller sequences accept, run steps and the final flush.
    pcxrle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_byte.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds configuration, position counters and the result registers.
    pcxrle_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start_image  (i_byte.start_image),
        .i_data_byte    (i_byte.data_byte),
        .i_out_ready    (o_pix.ready),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_pix.valid),
        .o_pixel_value  (o_pix.pixel_value),
        .o_pixel_row    (o_pix.pixel_row),
        .o_pixel_column (o_pix.pixel_column),
        .o_pixel_plane  (o_pix.pixel_plane),
        .o_last         (o_pix.last)
    );

    assign i_byte.ready = in_ready;

endmodule

[rtl/core/pcxrle_ctrl.sv]
// Controller state machine of the PCX run-length decoder.
module pcxrle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pcxrle_pkg::t_dp_stat i_stat,
    output pcxrle_pkg::t_dp_cmd  o_cmd
);

    pcxrle_pkg::t_state r_state;
    pcxrle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcxrle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output decode.
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.flush  = 1'b0;
        case (r_state)
            pcxrle_pkg::ST_IDLE: begin
                o_in_ready   = i_stat.out_free;
                o_cmd.accept = i_in_valid && i_stat.out_free;
            end
            pcxrle_pkg::ST_RUN: begin
                // A kept byte pushes the held one out, which needs a free output slot.
                o_cmd.step = !(i_stat.emit && i_stat.hold_valid && !i_stat.out_free);
            end
            pcxrle_pkg::ST_FLUSH: begin
                o_cmd.flush = !i_stat.hold_valid || i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcxrle_pkg::ST_IDLE: begin
                if (i_in_valid && i_stat.out_free && i_stat.go_run) begin
                    n_state = pcxrle_pkg::ST_RUN;
                end
            end
            pcxrle_pkg::ST_RUN: begin
                if (!(i_stat.emit && i_stat.hold_valid && !i_stat.out_free)
                    && (i_stat.count_last || i_stat.line_end)) begin
                    n_state = pcxrle_pkg::ST_FLUSH;
                end
            end
            pcxrle_pkg::ST_FLUSH: begin
                if (!i_stat.hold_valid || i_stat.out_free) begin
                    n_state = pcxrle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcxrle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/pcxrle_dp.sv]
// Datapath of the PCX run-length decoder: configuration, decode position and result registers.
module pcxrle_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_start_image,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_out_ready,
    input  pcxrle_pkg::t_dp_cmd   i_cmd,
    output pcxrle_pkg::t_dp_stat  o_stat,
    output logic                 o_out_valid,
    output logic [7:0]           o_pixel_value,
    output logic [14:0]          o_pixel_row,
    output logic [14:0]          o_pixel_column,
    output logic [1:0]           o_pixel_plane,
    output logic                 o_last
);

    localparam logic [15:0] MAX_DIM = 16'(pcxrle_pkg::MAX_DIMENSION);
    localparam logic [2:0]  MAX_PL  = 3'(pcxrle_pkg::MAX_PLANES);

    logic [15:0] r_width, r_height, r_line;
    logic [2:0]  r_planes;
    logic        r_await, n_await;
    logic [5:0]  r_pending, n_pending;
    logic [15:0] r_col, n_col;
    logic [1:0]  r_plane, n_plane;
    logic [15:0] r_row, n_row;
    logic        r_done, n_done;
    logic [7:0]  r_run_val;
    logic [5:0]  r_run_cnt;

    logic        r_hold_v;
    logic [7:0]  r_hold_val;
    logic [14:0] r_hold_row, r_hold_col;
    logic [1:0]  r_hold_pl;

    logic        r_out_v;
    logic [7:0]  r_out_val;
    logic [14:0] r_out_row, r_out_col;
    logic [1:0]  r_out_pl;
    logic        r_out_last;

    logic [15:0] eff_w, eff_h, eff_l;
    logic [2:0]  eff_p;
    logic        s_await;
    logic [5:0]  s_pending;
    logic [15:0] s_col, s_row;
    logic [1:0]  s_plane;
    logic        s_done;
    logic        finished;
    logic        is_header;
    logic        out_free;
    logic [15:0] p_col, p_row;
    logic [1:0]  p_plane;
    pcxrle_pkg::t_place pl;

    assign eff_w = (r_width > MAX_DIM) ? MAX_DIM : r_width;
    assign eff_h = (r_height > MAX_DIM) ? MAX_DIM : r_height;
    assign eff_l = (r_line == 16'd0) ? 16'd1 : r_line;
    assign eff_p = (r_planes == 3'd0) ? 3'd1 : ((r_planes > MAX_PL) ? MAX_PL : r_planes);

    // A start request clears the position before the byte is looked at.
    assign s_await   = i_start_image ? 1'b0  : r_await;
    assign s_pending = i_start_image ? 6'd0  : r_pending;
    assign s_col     = i_start_image ? 16'd0 : r_col;
    assign s_plane   = i_start_image ? 2'd0  : r_plane;
    assign s_row     = i_start_image ? 16'd0 : r_row;
    assign s_done    = i_start_image ? 1'b0  : r_done;
    assign finished  = s_done || (s_row >= eff_h);
    assign is_header = ((i_data_byte & pcxrle_pkg::RUN_MARK_MASK) == pcxrle_pkg::RUN_MARK_MASK);

    // One placement unit, fed by the accepted literal or by the current run step.
    assign p_col   = i_cmd.accept ? s_col : r_col;
    assign p_plane = i_cmd.accept ? s_plane : r_plane;
    assign p_row   = i_cmd.accept ? s_row : r_row;
    assign pl      = pcxrle_pkg::place_byte(p_col, p_plane, p_row, eff_w, eff_l, eff_p, eff_h);

    assign out_free = !r_out_v || i_out_ready;

    assign o_stat.go_run     = !finished && s_await && (s_pending != 6'd0);
    assign o_stat.emit       = pl.emit;
    assign o_stat.line_end   = pl.line_end;
    assign o_stat.count_last = (r_run_cnt == 6'd1);
    assign o_stat.hold_valid = r_hold_v;
    assign o_stat.out_free   = out_free;

    always_comb begin
        n_await   = r_await;
        n_pending = r_pending;
        n_col     = r_col;
        n_plane   = r_plane;
        n_row     = r_row;
        n_done    = r_done;
        if (i_cmd.accept) begin
            n_await   = s_await;
            n_pending = s_pending;
            n_col     = s_col;
            n_plane   = s_plane;
            n_row     = s_row;
            n_done    = s_done;
            if (!finished) begin
                if (s_await) begin
                    n_await   = 1'b0;
                    n_pending = 6'd0;
                end else if (is_header) begin
                    n_await   = 1'b1;
                    n_pending = i_data_byte[5:0] & pcxrle_pkg::RUN_CNT_MASK[5:0];
                end else begin
                    n_col   = pl.col;
                    n_plane = pl.plane;
                    n_row   = pl.row;
                    n_done  = s_done | pl.done_set;
                end
            end
        end else if (i_cmd.step) begin
            n_col   = pl.col;
            n_plane = pl.plane;
            n_row   = pl.row;
            n_done  = r_done | pl.done_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= 16'd1;
            r_height  <= 16'd1;
            r_line    <= 16'd1;
            r_planes  <= 3'd1;
            r_await   <= 1'b0;
            r_pending <= 6'd0;
            r_col     <= 16'd0;
            r_plane   <= 2'd0;
            r_row     <= 16'd0;
            r_done    <= 1'b0;
            r_hold_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pcxrle_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    pcxrle_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    pcxrle_pkg::CFG_LINE_BYTES:   r_line   <= i_cfg_data;
                    pcxrle_pkg::CFG_PLANE_COUNT:  r_planes <= i_cfg_data[2:0];
                    default: r_planes <= r_planes;
                endcase
            end
            r_await   <= n_await;
            r_pending <= n_pending;
            r_col     <= n_col;
            r_plane   <= n_plane;
            r_row     <= n_row;
            r_done    <= n_done;

            if (i_cmd.accept && !finished && !s_await && !is_header && pl.emit) begin
                r_out_v <= 1'b1;
            end else if (i_cmd.step && pl.emit && r_hold_v) begin
                r_out_v <= 1'b1;
            end else if (i_cmd.flush && r_hold_v) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end

            if (i_cmd.step && pl.emit) begin
                r_hold_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hold_v <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_run_val <= i_data_byte;
            r_run_cnt <= s_pending;
        end else if (i_cmd.step) begin
            r_run_cnt <= r_run_cnt - 6'd1;
        end

        if (i_cmd.accept) begin
            r_out_val  <= i_data_byte;
            r_out_row  <= s_row[14:0];
            r_out_col  <= s_col[14:0];
            r_out_pl   <= s_plane;
            r_out_last <= 1'b1;
        end else if ((i_cmd.step && pl.emit && r_hold_v) || i_cmd.flush) begin
            r_out_val  <= r_hold_val;
            r_out_row  <= r_hold_row;
            r_out_col  <= r_hold_col;
            r_out_pl   <= r_hold_pl;
            r_out_last <= i_cmd.flush;
        end

        if (i_cmd.step && pl.emit) begin
            r_hold_val <= r_run_val;
            r_hold_row <= r_row[14:0];
            r_hold_col <= r_col[14:0];
            r_hold_pl  <= r_plane;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_pixel_value  = r_out_val;
    assign o_pixel_row    = r_out_row;
    assign o_pixel_column = r_out_col;
    assign o_pixel_plane  = r_out_pl;
    assign o_last         = r_out_last;

endmodule
